// ----- sv/bbox_mask_rasterizer_assert.svh -----
// assertion macros for the bbox mask rasterizer
`ifndef BBOX_MASK_RASTERIZER_ASSERT_SVH
`define BBOX_MASK_RASTERIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BMR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BMR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bmr_pkg.sv -----
// types, constants and helpers shared by the bbox mask rasterizer
package bmr_pkg;

    localparam int MAX_COLUMNS   = 64;
    localparam int MAX_ROWS      = 64;
    localparam int MAX_GRID_SIDE = 8;

    // divider sizing: numerator is (edge) * map dimension < 2^22, divisor is an image size
    localparam int NUM_W  = 22;
    localparam int DEN_W  = 16;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int LANES  = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_MAP_COLUMNS = 2'd0,
        CFG_MAP_ROWS    = 2'd1,
        CFG_GRID_SIDE   = 2'd2,
        CFG_DRAW_MODE   = 2'd3
    } cfg_reg_t;

    localparam logic MODE_AREA   = 1'b0;
    localparam logic MODE_CENTER = 1'b1;

    typedef struct packed {
        logic [15:0] image_columns;
        logic [15:0] image_rows;
        logic [2:0]  cell_row;
        logic [2:0]  cell_col;
        logic [15:0] left_edge;
        logic [15:0] top_edge;
        logic [15:0] right_edge;
        logic [15:0] bottom_edge;
    } box_item_t;

    typedef struct packed {
        logic [5:0]  row_number;
        logic [5:0]  channel_number;
        logic [63:0] row_mask;
        logic        out_of_range;
        logic        last_row;
    } row_item_t;

    // clamped configuration seen by the datapath
    typedef struct packed {
        logic [6:0] mc;
        logic [6:0] mr;
        logic [3:0] gs;
        logic       mode;
    } cfg_t;

    // classified box handed from front to back
    typedef struct packed {
        logic [5:0]  ch;
        logic        bad;
        logic [6:0]  y0;
        logic [6:0]  y1;
        logic [63:0] mask;
    } qent_t;

    function automatic logic [6:0] clamp_map(input logic [6:0] v, input logic [6:0] maxv);
        logic [6:0] r;
        if (v == 7'd0)
        begin
            r = 7'd1;
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [3:0] clamp_grid(input logic [3:0] v);
        logic [3:0] r;
        if (v == 4'd0)
        begin
            r = 4'd1;
        end
        else if (v > 4'(MAX_GRID_SIDE))
        begin
            r = 4'(MAX_GRID_SIDE);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- sv/bmr_div.sv -----
// restoring divider, one quotient bit per cycle
module bmr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bmr_pkg::NUM_W-1:0] numer,
    input  logic [bmr_pkg::DEN_W-1:0] denom,
    output logic                      running,
    output logic [bmr_pkg::NUM_W-1:0] quot
);
    import bmr_pkg::*;

    logic [NUM_W-1:0]  work_reg;
    logic [NUM_W-1:0]  work_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  denom_reg;
    logic [STEP_W-1:0] count_reg;
    logic [STEP_W-1:0] count_next;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign running = (count_reg != '0);
    assign quot    = work_reg;

    always_comb
    begin
        shifted    = {rem_reg, work_reg[NUM_W-1]};
        fits       = (shifted >= {1'b0, denom_reg});
        diff       = shifted - {1'b0, denom_reg};
        rem_next   = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        work_next  = {work_reg[NUM_W-2:0], fits};
        count_next = count_reg - STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (start)
        begin
            count_reg <= STEP_W'(NUM_W);
        end
        else if (running)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg  <= numer;
            rem_reg   <= '0;
            denom_reg <= denom;
        end
        else if (running)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

// ----- sv/bmr_front.sv -----
// front end: takes box items, scales the edges and classifies them into queue entries
module bmr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  bmr_pkg::cfg_t      cfg,
    input  logic               box_valid,
    output logic               box_ready,
    input  bmr_pkg::box_item_t box,
    output logic               push_valid,
    input  logic               push_ready,
    output bmr_pkg::qent_t     push_data
);
    import bmr_pkg::*;

    // multiply stage
    logic             a_valid_reg;
    logic             a_valid_next;
    logic [NUM_W-1:0] a_num_reg [LANES];
    logic [DEN_W-1:0] a_den_x_reg;
    logic [DEN_W-1:0] a_den_y_reg;
    logic [5:0]       a_ch_reg;
    logic             a_bad_reg;

    // divide stage
    logic             d_valid_reg;
    logic             d_valid_next;
    logic [5:0]       d_ch_reg;
    logic             d_bad_reg;

    logic             accept;
    logic             launch;
    logic             div_done;
    logic [LANES-1:0] lane_running;
    logic [NUM_W-1:0] quot [LANES];

    logic [15:0]      opnd [LANES];
    logic [6:0]       scale [LANES];
    logic [NUM_W-1:0] num [LANES];
    logic [DEN_W-1:0] img_w;
    logic [DEN_W-1:0] img_h;
    logic [16:0]      sum_x;
    logic [16:0]      sum_y;
    logic [6:0]       ch_full;
    logic [6:0]       ch_count;

    logic [6:0]       sx;
    logic [6:0]       ex;
    logic [6:0]       sy;
    logic [6:0]       ey;
    logic             center_off;
    qent_t            ent;

    function automatic logic [15:0] edge_less_one(input logic [15:0] e);
        return (e == 16'd0) ? 16'd0 : (e - 16'd1);
    endfunction

    function automatic logic [6:0] clamp_q(input logic [NUM_W-1:0] q, input logic [6:0] m);
        return (q > NUM_W'(m)) ? m : q[6:0];
    endfunction

    assign launch    = a_valid_reg && (!d_valid_reg || (div_done && push_ready));
    assign box_ready = !a_valid_reg || launch;
    assign accept    = box_valid && box_ready;
    assign div_done  = d_valid_reg && (lane_running == '0);

    // operand selection and scaling multiply
    always_comb
    begin
        img_w = (box.image_columns == 16'd0) ? 16'd1 : box.image_columns;
        img_h = (box.image_rows == 16'd0) ? 16'd1 : box.image_rows;
        sum_x = {1'b0, box.left_edge} + {1'b0, box.right_edge};
        sum_y = {1'b0, box.top_edge} + {1'b0, box.bottom_edge};
        if (cfg.mode == MODE_CENTER)
        begin
            opnd[0] = sum_x[16:1];
            opnd[2] = sum_y[16:1];
        end
        else
        begin
            opnd[0] = edge_less_one(box.left_edge);
            opnd[2] = edge_less_one(box.top_edge);
        end
        opnd[1]  = edge_less_one(box.right_edge);
        opnd[3]  = edge_less_one(box.bottom_edge);
        scale[0] = cfg.mc;
        scale[1] = cfg.mc;
        scale[2] = cfg.mr;
        scale[3] = cfg.mr;
        for (int i = 0; i < LANES; i++)
        begin
            num[i] = NUM_W'(opnd[i]) * NUM_W'(scale[i]);
        end
        ch_full  = 7'(box.cell_row) * 7'(cfg.gs) + 7'(box.cell_col);
        ch_count = 7'(cfg.gs) * 7'(cfg.gs);
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (launch)
        begin
            a_valid_next = 1'b0;
        end
        d_valid_next = d_valid_reg;
        if (launch)
        begin
            d_valid_next = 1'b1;
        end
        else if (div_done && push_ready)
        begin
            d_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                a_num_reg[i] <= num[i];
            end
            a_den_x_reg <= img_w;
            a_den_y_reg <= img_h;
            a_ch_reg    <= ch_full[5:0];
            a_bad_reg   <= (ch_full >= ch_count);
        end
        if (launch)
        begin
            d_ch_reg  <= a_ch_reg;
            d_bad_reg <= a_bad_reg;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        bmr_div u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (launch),
            .numer   (a_num_reg[g]),
            .denom   ((g < 2) ? a_den_x_reg : a_den_y_reg),
            .running (lane_running[g]),
            .quot    (quot[g])
        );
    end

    // classify the scaled box into a row range and a column mask
    always_comb
    begin
        sx         = clamp_q(quot[0], cfg.mc);
        ex         = clamp_q(quot[1], cfg.mc);
        sy         = clamp_q(quot[2], cfg.mr);
        ey         = clamp_q(quot[3], cfg.mr);
        center_off = (quot[0] >= NUM_W'(cfg.mc)) || (quot[2] >= NUM_W'(cfg.mr));
        ent.ch     = d_ch_reg;
        if (cfg.mode == MODE_CENTER)
        begin
            ent.bad = d_bad_reg || center_off;
            ent.y0  = quot[2][6:0];
            ent.y1  = quot[2][6:0] + 7'd1;
            for (int x = 0; x < 64; x++)
            begin
                ent.mask[x] = (quot[0] == NUM_W'(x));
            end
        end
        else
        begin
            ent.bad = d_bad_reg;
            ent.y0  = sy;
            ent.y1  = ey;
            for (int x = 0; x < 64; x++)
            begin
                ent.mask[x] = (7'(x) >= sx) && (7'(x) < ex);
            end
        end
    end

    assign push_valid = div_done;
    assign push_data  = ent;

endmodule

// ----- sv/bmr_queue.sv -----
// short queue of classified boxes between front and back
module bmr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  bmr_pkg::qent_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output bmr_pkg::qent_t pop_data
);
    import bmr_pkg::*;

    qent_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : (p + QPTR_W'(1));
    endfunction

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/bmr_back.sv -----
// back end: walks the map rows of one classified box and drives the output register
module bmr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bmr_pkg::cfg_t      cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  bmr_pkg::qent_t     pop_data,
    output logic               row_valid,
    input  logic               row_ready,
    output bmr_pkg::row_item_t row
);
    import bmr_pkg::*;

    logic      cur_valid_reg;
    logic      cur_valid_next;
    qent_t     cur_reg;
    logic [5:0] row_cnt_reg;
    logic [5:0] row_cnt_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    row_item_t out_reg;
    row_item_t out_next;
    logic      load;
    logic      at_last;
    logic      in_band;

    assign load      = cur_valid_reg && (!out_valid_reg || row_ready);
    assign at_last   = (7'(row_cnt_reg) == (cfg.mr - 7'd1));
    assign pop_ready = !cur_valid_reg || (load && at_last);
    assign in_band   = (7'(row_cnt_reg) >= cur_reg.y0) && (7'(row_cnt_reg) < cur_reg.y1);

    always_comb
    begin
        out_next.row_number     = row_cnt_reg;
        out_next.channel_number = cur_reg.ch;
        out_next.row_mask       = (!cur_reg.bad && in_band) ? cur_reg.mask : '0;
        out_next.out_of_range   = cur_reg.bad;
        out_next.last_row       = at_last;

        cur_valid_next = cur_valid_reg;
        row_cnt_next   = row_cnt_reg;
        if (pop_valid && pop_ready)
        begin
            cur_valid_next = 1'b1;
            row_cnt_next   = '0;
        end
        else if (load)
        begin
            cur_valid_next = !at_last;
            row_cnt_next   = row_cnt_reg + 6'd1;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (row_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            cur_reg <= pop_data;
        end
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign row_valid = out_valid_reg;
    assign row       = out_reg;

endmodule

// ----- sv/bbox_mask_rasterizer.sv -----
// bounding box to channel mask rasterizer, one map row per output item
// overlap: the front can take a new box while the 22-step divider and the row emitter work on
// earlier boxes; the row emitter sends one row per cycle while row_ready holds high
// reset: map 64 by 64, grid side 1, area mode; queue and all stages empty, no clearing pass
`include "bbox_mask_rasterizer_assert.svh"

module bbox_mask_rasterizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               box_valid,
    output logic               box_ready,
    input  bmr_pkg::box_item_t box,
    output logic               row_valid,
    input  logic               row_ready,
    output bmr_pkg::row_item_t row
);
    import bmr_pkg::*;

    logic [6:0] map_columns_reg;
    logic [6:0] map_rows_reg;
    logic [3:0] grid_side_reg;
    logic       draw_mode_reg;
    cfg_t       cfg;

    logic       push_valid;
    logic       push_ready;
    qent_t      push_data;
    logic       pop_valid;
    logic       pop_ready;
    qent_t      pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_columns_reg <= 7'(MAX_COLUMNS);
            map_rows_reg    <= 7'(MAX_ROWS);
            grid_side_reg   <= 4'd1;
            draw_mode_reg   <= MODE_AREA;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAP_COLUMNS: map_columns_reg <= cfg_data;
                CFG_MAP_ROWS:    map_rows_reg    <= cfg_data;
                CFG_GRID_SIDE:   grid_side_reg   <= cfg_data[3:0];
                CFG_DRAW_MODE:   draw_mode_reg   <= cfg_data[0];
                default:         draw_mode_reg   <= draw_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.mc   = clamp_map(map_columns_reg, 7'(MAX_COLUMNS));
        cfg.mr   = clamp_map(map_rows_reg, 7'(MAX_ROWS));
        cfg.gs   = clamp_grid(grid_side_reg);
        cfg.mode = draw_mode_reg;
    end

    bmr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .box_valid  (box_valid),
        .box_ready  (box_ready),
        .box        (box),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bmr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bmr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row)
    );

    `BMR_ASSERT_NOW(a_flag_clears_mask, row_valid && row.out_of_range, row.row_mask == 64'd0, "mask set on out of range item")
    `BMR_ASSERT_NOW(a_last_row_at_end, row_valid && row.last_row, 7'(row.row_number) == (cfg.mr - 7'd1), "last row flag on wrong row")
    `BMR_ASSERT_NEXT(a_rows_continue, row_valid && row_ready && !row.last_row, row_valid && (row.row_number == $past(row.row_number) + 6'd1), "row sequence broken")

endmodule
